/* rtl/core/fss_pkg.sv */
// Package with shared types and constants for the fair share scheduler.
package fss_pkg;

    localparam int unsigned MAX_PROCS_DEF = 16;
    localparam logic [15:0] QUANTUM_RESET = 16'd10;
    localparam logic [31:0] U32_MAX       = 32'hFFFF_FFFF;

    localparam logic       REQ_ADMIT = 1'b0;
    localparam logic       REQ_STEP  = 1'b1;

    localparam logic [2:0] KIND_ADMITTED   = 3'd0;
    localparam logic [2:0] KIND_DISPATCHED = 3'd1;
    localparam logic [2:0] KIND_IDLE       = 3'd2;
    localparam logic [2:0] KIND_ALL_DONE   = 3'd3;
    localparam logic [2:0] KIND_FULL       = 3'd4;

    localparam logic [1:0] REG_QUANTUM = 2'd0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADMIT_SCAN,
        ST_ADMIT_WRITE,
        ST_ARR_SCAN,
        ST_ARR_MARK,
        ST_PICK_SCAN,
        ST_RUN_CALC,
        ST_RUN_MUL,
        ST_RUN_WRITE,
        ST_RESULT
    } fss_state_t;

    typedef struct packed {
        logic clear_scan;
        logic scan_step;
        logic scan_free;
        logic scan_arrival;
        logic scan_pick;
        logic admit_write;
        logic mark_ready;
        logic run_calc;
        logic run_mul;
        logic run_write;
        logic idle_tick;
        logic set_full;
        logic set_done;
        logic load_in;
    } fss_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic found;
        logic live_zero;
        logic req_step;
    } fss_stat_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] out_proc_id;
        logic [31:0] start_time;
        logic [15:0] run_length;
        logic        first_run;
        logic [31:0] latency;
        logic        finished;
        logic [31:0] turnaround;
        logic [31:0] ready_wait;
        logic [31:0] virtual_runtime;
    } fss_result_t;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? U32_MAX : s[31:0];
    endfunction

endpackage

/* rtl/core/fss_ctrl.sv */
// Controller state machine sequencing admits, arrival sweeps, picks and dispatches.
module fss_ctrl
    import fss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic       out_busy,
    input  fss_stat_t  stat,
    output fss_cmd_t   cmd,
    output logic       idle,
    output logic       result_push
);

    fss_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        result_push = 1'b0;
        idle        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                idle = 1'b1;
                if (in_fire)
                begin
                    cmd.load_in    = 1'b1;
                    cmd.clear_scan = 1'b1;
                    state_next     = ST_ADMIT_SCAN;
                end
            end
            ST_ADMIT_SCAN:
            begin
                if (stat.req_step)
                begin
                    if (stat.live_zero)
                    begin
                        cmd.set_done = 1'b1;
                        state_next   = ST_RESULT;
                    end
                    else
                    begin
                        state_next = ST_ARR_SCAN;
                    end
                end
                else
                begin
                    cmd.scan_free = 1'b1;
                    cmd.scan_step = 1'b1;
                    if (stat.scan_last)
                    begin
                        state_next = ST_ADMIT_WRITE;
                    end
                end
            end
            ST_ADMIT_WRITE:
            begin
                if (stat.found)
                begin
                    cmd.admit_write = 1'b1;
                end
                else
                begin
                    cmd.set_full = 1'b1;
                end
                state_next = ST_RESULT;
            end
            ST_ARR_SCAN:
            begin
                cmd.scan_arrival = 1'b1;
                cmd.scan_step    = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_ARR_MARK;
                end
            end
            ST_ARR_MARK:
            begin
                cmd.clear_scan = 1'b1;
                if (stat.found)
                begin
                    cmd.mark_ready = 1'b1;
                    state_next     = ST_ARR_SCAN;
                end
                else
                begin
                    state_next = ST_PICK_SCAN;
                end
            end
            ST_PICK_SCAN:
            begin
                cmd.scan_pick = 1'b1;
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_RUN_CALC;
                end
            end
            ST_RUN_CALC:
            begin
                if (stat.found)
                begin
                    cmd.run_calc = 1'b1;
                    state_next   = ST_RUN_MUL;
                end
                else
                begin
                    cmd.idle_tick = 1'b1;
                    state_next    = ST_RESULT;
                end
            end
            ST_RUN_MUL:
            begin
                cmd.run_mul = 1'b1;
                state_next  = ST_RUN_WRITE;
            end
            ST_RUN_WRITE:
            begin
                cmd.run_write = 1'b1;
                state_next    = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_busy)
                begin
                    result_push = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        result_push |-> !out_busy)
        else $error("result pushed into a full output register");
    a_push_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_push |=> state_reg == ST_IDLE)
        else $error("controller did not return to idle after a result");
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> idle)
        else $error("word accepted while busy");
`endif

endmodule

/* rtl/core/fss_datapath.sv */
// Datapath holding the process table, scan comparator and dispatch arithmetic.
module fss_datapath
    import fss_pkg::*;
#(
    parameter int unsigned MAX_PROCS = MAX_PROCS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  fss_cmd_t    cmd,
    input  logic        in_req_type,
    input  logic [15:0] in_proc_id,
    input  logic [31:0] in_arrival_time,
    input  logic [15:0] in_burst,
    input  logic [7:0]  in_weight,
    input  logic [15:0] quantum,
    output fss_stat_t   stat,
    output fss_result_t result
);

    localparam int unsigned IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int unsigned CW = $clog2(MAX_PROCS + 1);

    logic [MAX_PROCS-1:0] used_reg;
    logic [MAX_PROCS-1:0] ready_reg;

    logic [15:0] pid_mem      [MAX_PROCS];
    logic [31:0] arrival_mem  [MAX_PROCS];
    logic [15:0] remain_mem   [MAX_PROCS];
    logic [15:0] burst_mem    [MAX_PROCS];
    logic [7:0]  weight_mem   [MAX_PROCS];
    logic [31:0] vrt_mem      [MAX_PROCS];
    logic        started_mem  [MAX_PROCS];
    logic [31:0] lat_mem      [MAX_PROCS];
    logic [31:0] stamp_mem    [MAX_PROCS];

    logic [31:0] sim_time_reg;
    logic [31:0] stamp_ctr_reg;
    logic [CW-1:0] live_reg;

    logic        req_type_reg;
    logic [15:0] pid_in_reg;
    logic [31:0] arr_in_reg;
    logic [15:0] burst_in_reg;
    logic [7:0]  weight_in_reg;

    logic [IW-1:0] idx_reg;
    logic          found_reg;
    logic [IW-1:0] best_reg;
    logic [31:0]   best_vrt_reg;
    logic [7:0]    best_w_reg;
    logic [31:0]   best_stamp_reg;

    logic [15:0]   run_reg;
    logic [31:0]   prod_reg;
    logic          first_reg;
    logic [31:0]   lat_reg;

    fss_result_t   res_reg;

    logic [31:0] c_vrt, c_stamp, c_arr;
    logic [7:0]  c_w;
    logic        cand, better;
    logic [15:0] q_eff, rem_new;
    logic [31:0] vrt_new, time_new, ta, stamp_next;
    logic [15:0] b_burst;

    assign c_vrt   = vrt_mem[idx_reg];
    assign c_stamp = stamp_mem[idx_reg];
    assign c_arr   = arrival_mem[idx_reg];
    assign c_w     = weight_mem[idx_reg];

    always_comb
    begin
        cand   = 1'b0;
        better = 1'b0;
        if (cmd.scan_free)
        begin
            cand = !used_reg[idx_reg] && !found_reg;
        end
        else if (cmd.scan_arrival)
        begin
            cand   = used_reg[idx_reg] && !ready_reg[idx_reg] && (c_arr <= sim_time_reg);
            better = !found_reg || (c_stamp < best_stamp_reg);
        end
        else if (cmd.scan_pick)
        begin
            cand = used_reg[idx_reg] && ready_reg[idx_reg];
            if (!found_reg)
                better = 1'b1;
            else if (c_vrt != best_vrt_reg)
                better = c_vrt < best_vrt_reg;
            else if (c_w != best_w_reg)
                better = c_w < best_w_reg;
            else
                better = c_stamp < best_stamp_reg;
        end
        if (cmd.scan_free)
        begin
            better = 1'b1;
        end
    end

    assign q_eff      = (quantum == 16'd0) ? 16'd1 : quantum;
    assign rem_new    = remain_mem[best_reg] - run_reg;
    assign vrt_new    = sat_add32(vrt_mem[best_reg], prod_reg);
    assign time_new   = sat_add32(sim_time_reg, {16'd0, run_reg});
    assign ta         = time_new - arrival_mem[best_reg];
    assign b_burst    = burst_mem[best_reg];
    assign stamp_next = (stamp_ctr_reg != U32_MAX) ? stamp_ctr_reg + 32'd1 : stamp_ctr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            ready_reg     <= '0;
            sim_time_reg  <= '0;
            stamp_ctr_reg <= '0;
            live_reg      <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            req_type_reg  <= REQ_ADMIT;
        end
        else
        begin
            if (cmd.load_in)
            begin
                req_type_reg <= in_req_type;
            end
            if (cmd.clear_scan)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                idx_reg <= (stat.scan_last) ? '0 : idx_reg + 1'b1;
                if (cand && better)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.admit_write)
            begin
                used_reg[best_reg]  <= 1'b1;
                ready_reg[best_reg] <= 1'b0;
                stamp_ctr_reg       <= stamp_next;
                live_reg            <= live_reg + 1'b1;
            end
            if (cmd.mark_ready)
            begin
                ready_reg[best_reg] <= 1'b1;
                stamp_ctr_reg       <= stamp_next;
            end
            if (cmd.idle_tick)
            begin
                sim_time_reg <= sat_add32(sim_time_reg, 32'd1);
            end
            if (cmd.run_write)
            begin
                sim_time_reg <= time_new;
                if (rem_new == 16'd0)
                begin
                    used_reg[best_reg]  <= 1'b0;
                    ready_reg[best_reg] <= 1'b0;
                    if (live_reg != '0)
                        live_reg <= live_reg - 1'b1;
                end
                else
                begin
                    stamp_ctr_reg <= stamp_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            pid_in_reg    <= in_proc_id;
            arr_in_reg    <= in_arrival_time;
            burst_in_reg  <= in_burst;
            weight_in_reg <= in_weight;
            res_reg       <= '0;
        end
        if (cmd.scan_step && cand && better)
        begin
            best_reg       <= idx_reg;
            best_vrt_reg   <= c_vrt;
            best_w_reg     <= c_w;
            best_stamp_reg <= c_stamp;
        end
        if (cmd.admit_write)
        begin
            pid_mem[best_reg]     <= pid_in_reg;
            arrival_mem[best_reg] <= arr_in_reg;
            burst_mem[best_reg]   <= burst_in_reg;
            remain_mem[best_reg]  <= burst_in_reg;
            weight_mem[best_reg]  <= weight_in_reg;
            vrt_mem[best_reg]     <= '0;
            started_mem[best_reg] <= 1'b0;
            lat_mem[best_reg]     <= '0;
            stamp_mem[best_reg]   <= stamp_ctr_reg;
            res_reg.kind          <= KIND_ADMITTED;
            res_reg.out_proc_id   <= pid_in_reg;
        end
        if (cmd.set_full)
        begin
            res_reg.kind        <= KIND_FULL;
            res_reg.out_proc_id <= pid_in_reg;
        end
        if (cmd.set_done)
        begin
            res_reg.kind <= KIND_ALL_DONE;
        end
        if (cmd.mark_ready)
        begin
            stamp_mem[best_reg] <= stamp_ctr_reg;
        end
        if (cmd.idle_tick)
        begin
            res_reg.kind       <= KIND_IDLE;
            res_reg.start_time <= sat_add32(sim_time_reg, 32'd1);
        end
        if (cmd.run_calc)
        begin
            run_reg   <= (remain_mem[best_reg] < q_eff) ? remain_mem[best_reg] : q_eff;
            first_reg <= !started_mem[best_reg];
            lat_reg   <= started_mem[best_reg] ? lat_mem[best_reg]
                                               : sim_time_reg - arrival_mem[best_reg];
        end
        if (cmd.run_mul)
        begin
            prod_reg <= {16'd0, run_reg} * {24'd0, weight_mem[best_reg]};
        end
        if (cmd.run_write)
        begin
            started_mem[best_reg] <= 1'b1;
            lat_mem[best_reg]     <= lat_reg;
            remain_mem[best_reg]  <= rem_new;
            vrt_mem[best_reg]     <= vrt_new;
            res_reg.kind            <= KIND_DISPATCHED;
            res_reg.out_proc_id     <= pid_mem[best_reg];
            res_reg.start_time      <= sim_time_reg;
            res_reg.run_length      <= run_reg;
            res_reg.first_run       <= first_reg;
            res_reg.latency         <= lat_reg;
            res_reg.virtual_runtime <= vrt_new;
            if (rem_new == 16'd0)
            begin
                res_reg.finished   <= 1'b1;
                res_reg.turnaround <= ta;
                res_reg.ready_wait <= (ta >= {16'd0, b_burst}) ? ta - {16'd0, b_burst} : '0;
            end
            else
            begin
                stamp_mem[best_reg] <= stamp_ctr_reg;
            end
        end
    end

    assign stat.scan_last = (idx_reg == IW'(MAX_PROCS - 1));
    assign stat.found     = found_reg;
    assign stat.live_zero = (live_reg == '0);
    assign stat.req_step  = (req_type_reg == REQ_STEP);
    assign result         = res_reg;

`ifndef NO_ASSERTIONS
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= CW'(MAX_PROCS))
        else $error("live count beyond table size");
    a_ready_used: assert property (@(posedge clk) disable iff (!rst_n)
        (ready_reg & ~used_reg) == '0)
        else $error("ready slot that is not in use");
    a_admit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.admit_write |-> !used_reg[best_reg])
        else $error("admit into a used slot");
`endif

endmodule

/* rtl/core/fair_share_scheduler_sim_unit.sv */
// Top level of the fair share scheduler with stream ports and an APB register port.
// An admit scans the slots for a free one, then writes it or reports the table full; a
// dispatching step sweeps arrivals until none is found, then picks, multiplies, writes.
// One word is taken at a time, held off by the serial slot scans of the controller.
// The output register holds one result, so the next word is taken while it waits.
// Reset (rst_n, asynchronous, active low) empties the table and clears time and counters.
module fair_share_scheduler_sim_unit
    import fss_pkg::*;
#(
    parameter int unsigned MAX_PROCS = MAX_PROCS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: proc_id[15:0], arrival_time[47:16], burst[63:48], weight[71:64]
    input  logic [71:0]  s_tdata,
    // tuser: req_type
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: out_proc_id, start_time, run_length, first_run, latency, finished,
    // turnaround, ready_wait, virtual_runtime (bits 0 to 193), zero padded
    output logic [199:0] m_tdata,
    // tuser: kind
    output logic [2:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    fss_cmd_t    cmd;
    fss_stat_t   stat;
    fss_result_t result;
    logic        idle, result_push, in_fire;
    logic        out_valid_reg;
    fss_result_t out_reg;
    logic [15:0] quantum_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_QUANTUM) ? {16'd0, quantum_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= QUANTUM_RESET;
        end
        else if (psel && penable && pwrite && paddr == REG_QUANTUM)
        begin
            quantum_reg <= pwdata[15:0];
        end
    end

    assign s_tready = idle;
    assign in_fire  = s_tvalid && s_tready;

    fss_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .out_busy    (out_valid_reg && !m_tready),
        .stat        (stat),
        .cmd         (cmd),
        .idle        (idle),
        .result_push (result_push)
    );

    fss_datapath #(.MAX_PROCS(MAX_PROCS)) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .in_req_type     (s_tuser),
        .in_proc_id      (s_tdata[15:0]),
        .in_arrival_time (s_tdata[47:16]),
        .in_burst        (s_tdata[63:48]),
        .in_weight       (s_tdata[71:64]),
        .quantum         (quantum_reg),
        .stat            (stat),
        .result          (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result_push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_push)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {6'd0, out_reg.virtual_runtime, out_reg.ready_wait, out_reg.turnaround,
                       out_reg.finished, out_reg.latency, out_reg.first_run,
                       out_reg.run_length, out_reg.start_time, out_reg.out_proc_id};

endmodule

/* tb/fair_share_scheduler_sim_unit_tb.sv */
// Self-checking testbench for the fair share scheduler with a built-in scheduling predictor.
`timescale 1ns / 1ps

module fair_share_scheduler_sim_unit_tb;
    import fss_pkg::*;

    class sched_scoreboard;
        logic        used [16];
        logic        ready [16];
        logic        started [16];
        logic [15:0] pid [16];
        logic [15:0] remaining [16];
        logic [15:0] burst [16];
        logic [7:0]  weight [16];
        logic [31:0] arrival [16];
        logic [31:0] vrt [16];
        logic [31:0] first_lat [16];
        logic [31:0] stamp [16];
        logic [31:0] now;
        logic [31:0] stamp_ctr;
        int          live;
        logic [15:0] quantum;
        fss_result_t expected_q [$];
        int          errors;

        function new();
            for (int i = 0; i < 16; i++)
            begin
                used[i] = 0;
                ready[i] = 0;
                started[i] = 0;
                pid[i] = 0;
                remaining[i] = 0;
                burst[i] = 0;
                weight[i] = 0;
                arrival[i] = 0;
                vrt[i] = 0;
                first_lat[i] = 0;
                stamp[i] = 0;
            end
            now = 0;
            stamp_ctr = 0;
            live = 0;
            quantum = QUANTUM_RESET;
            errors = 0;
        endfunction

        function logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
            logic [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? U32_MAX : s[31:0];
        endfunction

        function logic [31:0] take_stamp();
            logic [31:0] s;
            s = stamp_ctr;
            if (stamp_ctr != U32_MAX)
                stamp_ctr++;
            return s;
        endfunction

        function bit beats(int a, int b);
            if (vrt[a] != vrt[b])
                return vrt[a] < vrt[b];
            if (weight[a] != weight[b])
                return weight[a] < weight[b];
            return stamp[a] < stamp[b];
        endfunction

        function void note_word(logic req, logic [15:0] p, logic [31:0] arr,
                                logic [15:0] bst, logic [7:0] w);
            fss_result_t r;
            int          slot;
            int          pick;
            int          best;
            logic [15:0] q;
            logic [15:0] run;
            logic [31:0] ta;
            r = '0;
            slot = -1;
            pick = -1;
            if (req == REQ_ADMIT)
            begin
                r.out_proc_id = p;
                for (int i = 15; i >= 0; i--)
                    if (!used[i])
                        slot = i;
                if (slot < 0)
                    r.kind = KIND_FULL;
                else
                begin
                    r.kind = KIND_ADMITTED;
                    used[slot] = 1;
                    ready[slot] = 0;
                    pid[slot] = p;
                    arrival[slot] = arr;
                    burst[slot] = bst;
                    remaining[slot] = bst;
                    weight[slot] = w;
                    vrt[slot] = 0;
                    started[slot] = 0;
                    first_lat[slot] = 0;
                    stamp[slot] = take_stamp();
                    live++;
                end
            end
            else if (live == 0)
                r.kind = KIND_ALL_DONE;
            else
            begin
                for (int n = 0; n < 16; n++)
                begin
                    best = -1;
                    for (int i = 0; i < 16; i++)
                        if (used[i] && !ready[i] && arrival[i] <= now)
                            if (best < 0 || stamp[i] < stamp[best])
                                best = i;
                    if (best >= 0)
                    begin
                        ready[best] = 1;
                        stamp[best] = take_stamp();
                    end
                end
                for (int i = 0; i < 16; i++)
                    if (used[i] && ready[i] && (pick < 0 || beats(i, pick)))
                        pick = i;
                if (pick < 0)
                begin
                    now = add_sat(now, 1);
                    r.kind = KIND_IDLE;
                    r.start_time = now;
                end
                else
                begin
                    r.kind = KIND_DISPATCHED;
                    r.out_proc_id = pid[pick];
                    r.start_time = now;
                    if (!started[pick])
                    begin
                        started[pick] = 1;
                        first_lat[pick] = now - arrival[pick];
                        r.first_run = 1;
                    end
                    r.latency = first_lat[pick];
                    q = (quantum == 0) ? 16'd1 : quantum;
                    run = (remaining[pick] < q) ? remaining[pick] : q;
                    remaining[pick] -= run;
                    now = add_sat(now, {16'd0, run});
                    vrt[pick] = add_sat(vrt[pick], {16'd0, run} * {24'd0, weight[pick]});
                    r.run_length = run;
                    r.virtual_runtime = vrt[pick];
                    if (remaining[pick] == 0)
                    begin
                        ta = now - arrival[pick];
                        r.finished = 1;
                        r.turnaround = ta;
                        r.ready_wait = (ta >= burst[pick]) ? ta - burst[pick] : 32'd0;
                        used[pick] = 0;
                        ready[pick] = 0;
                        live--;
                    end
                    else
                        stamp[pick] = take_stamp();
                end
            end
            expected_q.push_back(r);
        endfunction

        function void field_check(string name, logic [31:0] e, logic [31:0] a);
            if (e !== a)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, e, a);
            end
        endfunction

        function void check_word(logic [2:0] kind, logic [199:0] d);
            fss_result_t e;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, expected none, actual kind %0d", $realtime, kind);
                return;
            end
            e = expected_q.pop_front();
            field_check("kind", e.kind, kind);
            field_check("out_proc_id", e.out_proc_id, d[15:0]);
            field_check("start_time", e.start_time, d[47:16]);
            field_check("run_length", e.run_length, d[63:48]);
            field_check("first_run", e.first_run, d[64]);
            field_check("latency", e.latency, d[96:65]);
            field_check("finished", e.finished, d[97]);
            field_check("turnaround", e.turnaround, d[129:98]);
            field_check("ready_wait", e.ready_wait, d[161:130]);
            field_check("virtual_runtime", e.virtual_runtime, d[193:162]);
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [71:0]  s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [199:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [1:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    sched_scoreboard sched = new();
    int              hold_len = 0;
    bit              no_idle = 0;

    fair_share_scheduler_sim_unit u_top (.*);

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int stall;
        int r;
        m_tready = 0;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sched.check_word(m_tuser, m_tdata);
            if (hold_len > 0)
            begin
                hold_len--;
                m_tready <= 0;
            end
            else if (stall > 0)
            begin
                stall--;
                m_tready <= 0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (!no_idle && r < 20)
                begin
                    stall = (r < 2) ? $urandom_range(20, 60) : $urandom_range(0, 2);
                    m_tready <= 0;
                end
                else
                    m_tready <= 1;
            end
        end
    end

    task automatic send_word(logic req, logic [15:0] p, logic [31:0] arr,
                             logic [15:0] bst, logic [7:0] w);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        gap = 0;
        if (!no_idle && r < 25)
            gap = $urandom_range(1, 3);
        else if (!no_idle && r < 28)
            gap = $urandom_range(15, 50);
        if (gap > 0)
        begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser <= req;
        s_tdata <= {w, bst, arr, p};
        do
            @(posedge clk);
        while (!s_tready);
        sched.note_word(req, p, arr, bst, w);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge clk);
        while (sched.expected_q.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_quantum(logic [15:0] v);
        @(posedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= REG_QUANTUM;
        pwdata <= {16'd0, v};
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        sched.quantum = v;
        pwrite <= 0;
        penable <= 0;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        if (prdata[15:0] !== v)
        begin
            sched.errors++;
            $display("%0t: quantum readback mismatch, expected %0h, actual %0h",
                     $realtime, v, prdata[15:0]);
        end
        psel <= 0;
        penable <= 0;
    endtask

    task automatic admit_near(int max_burst);
        logic [31:0] arr;
        logic [7:0]  w;
        int          r;
        r = $urandom_range(0, 99);
        arr = sched.now + $urandom_range(0, 25);
        if (r < 20)
            arr = (sched.now > 10) ? sched.now - $urandom_range(0, 10) : 32'd0;
        w = 8'($urandom_range(1, 255));
        if (r > 92)
            w = (r > 96) ? 8'd0 : 8'd255;
        send_word(REQ_ADMIT, 16'($urandom), arr,
                  (r == 50) ? 16'($urandom_range(0, max_burst * 8)) :
                  16'($urandom_range(0, max_burst)), w);
    endtask

    initial
    begin
        logic [15:0] qs [4];
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        write_quantum(QUANTUM_RESET);
        send_word(REQ_STEP, 16'd0, 32'd0, 16'd0, 8'd0);
        send_word(REQ_ADMIT, 16'd0, 32'd0, 16'd0, 8'd0);
        send_word(REQ_STEP, 16'd0, 32'd0, 16'd0, 8'd0);
        send_word(REQ_ADMIT, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
        send_word(REQ_STEP, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
        send_word(REQ_ADMIT, 16'h1234, 32'd3, 16'd25, 8'd1);
        send_word(REQ_ADMIT, 16'd2, 32'd2, 16'd5, 8'd2);
        send_word(REQ_ADMIT, 16'hABCD, 32'd0, 16'd12, 8'd0);
        repeat (6) send_word(REQ_STEP, 16'd0, 32'd0, 16'd0, 8'd0);
        repeat (14) admit_near(3);
        drain();

        qs[0] = 16'd1;
        qs[1] = 16'hFFFF;
        qs[2] = 16'd0;
        qs[3] = 16'($urandom_range(2, 40));
        for (int ph = 0; ph < 4; ph++)
        begin
            write_quantum(qs[ph]);
            no_idle = (ph == 2);
            for (int n = 0; n < 130; n++)
            begin
                if (ph == 1 && n == 40)
                    hold_len = 400;
                if ($urandom_range(0, 99) < 35)
                    admit_near((ph == 1) ? 8000 : 30);
                else
                    send_word(REQ_STEP, 16'($urandom), $urandom, 16'($urandom),
                              8'($urandom));
            end
            drain();
        end

        if (sched.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/core/fss_pkg.sv
rtl/core/fss_ctrl.sv
rtl/core/fss_datapath.sv
rtl/core/fair_share_scheduler_sim_unit.sv
tb/fair_share_scheduler_sim_unit_tb.sv
